FILE: src/fcrx_pkg.sv
`timescale 1ns / 1ps

package fcrx_pkg;

    localparam int RX_DEPTH = 16;
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_FRAME  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] IRQ_NONE  = 2'd0;
    localparam logic [1:0] IRQ_SET   = 2'd1;
    localparam logic [1:0] IRQ_CLEAR = 2'd2;

    localparam logic [7:0] ADDR_TX_ID   = 8'h00;
    localparam logic [7:0] ADDR_TX_DATA = 8'h04;
    localparam logic [7:0] ADDR_SEND    = 8'h08;
    localparam logic [7:0] ADDR_STATUS  = 8'h0C;
    localparam logic [7:0] ADDR_RX_ID   = 8'h10;
    localparam logic [7:0] ADDR_RX_DATA = 8'h14;
    localparam logic [7:0] ADDR_RX_POP  = 8'h18;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  addr;
        logic [2:0]  access_bytes;
        logic [31:0] wdata;
        logic [31:0] frame_id;
        logic [31:0] frame_data;
    } fcrx_req_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fcrx_fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } fcrx_fifo_status_t;

    function automatic logic [31:0] cut_to_size(input logic [31:0] v,
                                                input logic [2:0] nbytes);
        logic [31:0] r;
        begin
            case (nbytes)
                3'd1:    r = {24'd0, v[7:0]};
                3'd2:    r = {16'd0, v[15:0]};
                3'd3:    r = {8'd0, v[23:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: src/frame_controller_rx_fifo.sv
`timescale 1ns / 1ps
// A request taken at a clock edge is held in the input register; its result
// is captured in the result register and shown on the outputs with done high.
// Throughput: one request per cycle; busy is always low (input register,
// decode and FIFO update, result register).
// Reset: async active low; clears TX registers, FIFO head and count, done.
// FIFO entries are not cleared. The receiver cannot stall results.

module frame_controller_rx_fifo
    import fcrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  addr,
    input  logic [2:0]  access_bytes,
    input  logic [31:0] wdata,
    input  logic [31:0] frame_id,
    input  logic [31:0] frame_data,
    output logic        done,
    output logic [31:0] rdata,
    output logic        addr_error,
    output logic        tx_valid,
    output logic [31:0] sent_id,
    output logic [31:0] sent_data,
    output logic [1:0]  irq_event,
    output logic        rx_dropped
);

    logic              req_valid_reg;
    fcrx_req_t         req_reg;
    fcrx_fifo_ctrl_t   fifo_ctrl;
    fcrx_fifo_status_t fifo_status;
    logic [31:0]       head_id;
    logic [31:0]       head_data;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= '{req_type, addr, access_bytes, wdata, frame_id, frame_data};
        end
    end

    fcrx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_id   (req_reg.frame_id),
        .push_data (req_reg.frame_data),
        .status    (fifo_status),
        .head_id   (head_id),
        .head_data (head_data)
    );

    fcrx_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid_reg),
        .req         (req_reg),
        .fifo_status (fifo_status),
        .head_id     (head_id),
        .head_data   (head_data),
        .fifo_ctrl   (fifo_ctrl),
        .done        (done),
        .rdata       (rdata),
        .addr_error  (addr_error),
        .tx_valid    (tx_valid),
        .sent_id     (sent_id),
        .sent_data   (sent_data),
        .irq_event   (irq_event),
        .rx_dropped  (rx_dropped)
    );

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("request lost");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without request");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && rx_dropped |-> $past(fifo_status.full) && irq_event == IRQ_NONE)
        else $error("frame dropped with room in fifo");

    a_no_push_pop_together: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_ctrl.push && fifo_ctrl.pop))
        else $error("fifo push and pop in one cycle");

endmodule

FILE: src/fcrx_fifo.sv
`timescale 1ns / 1ps

module fcrx_fifo
    import fcrx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fcrx_fifo_ctrl_t   ctrl,
    input  logic [31:0]       push_id,
    input  logic [31:0]       push_data,
    output fcrx_fifo_status_t status,
    output logic [31:0]       head_id,
    output logic [31:0]       head_data
);

    logic [63:0]         entry_reg [RX_DEPTH];
    logic [63:0]         head_word_reg;
    logic [RX_PTR_W-1:0] head_reg;
    logic [RX_PTR_W-1:0] head_next;
    logic [RX_CNT_W-1:0] count_reg;
    logic [RX_CNT_W-1:0] count_next;
    logic [RX_CNT_W:0]   tail_sum;
    logic [RX_CNT_W:0]   tail_wrap;
    logic [RX_PTR_W-1:0] tail;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == RX_CNT_W'(RX_DEPTH));
    assign status.last  = (count_reg <= RX_CNT_W'(1));

    assign head_id   = head_word_reg[63:32];
    assign head_data = head_word_reg[31:0];

    assign tail_sum  = (RX_CNT_W + 1)'(head_reg) + (RX_CNT_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= (RX_CNT_W + 1)'(RX_DEPTH))
                       ? tail_sum - (RX_CNT_W + 1)'(RX_DEPTH) : tail_sum;
    assign tail      = tail_wrap[RX_PTR_W-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.push && !status.full)
        begin
            count_next = count_reg + RX_CNT_W'(1);
        end
        else if (ctrl.pop && !status.empty)
        begin
            count_next = count_reg - RX_CNT_W'(1);
            head_next  = (head_reg == RX_PTR_W'(RX_DEPTH - 1))
                         ? '0 : head_reg + RX_PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // head word follows the new head; a push into an empty fifo bypasses
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !status.full)
        begin
            entry_reg[tail] <= {push_id, push_data};
        end
        if (ctrl.push && status.empty)
        begin
            head_word_reg <= {push_id, push_data};
        end
        else
        begin
            head_word_reg <= entry_reg[head_next];
        end
    end

endmodule

FILE: src/fcrx_core.sv
`timescale 1ns / 1ps

module fcrx_core
    import fcrx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  fcrx_req_t         req,
    input  fcrx_fifo_status_t fifo_status,
    input  logic [31:0]       head_id,
    input  logic [31:0]       head_data,
    output fcrx_fifo_ctrl_t   fifo_ctrl,
    output logic              done,
    output logic [31:0]       rdata,
    output logic              addr_error,
    output logic              tx_valid,
    output logic [31:0]       sent_id,
    output logic [31:0]       sent_data,
    output logic [1:0]        irq_event,
    output logic              rx_dropped
);

    logic [31:0] tx_id_reg, tx_id_next;
    logic [31:0] tx_data_reg, tx_data_next;
    logic        done_reg;
    logic [31:0] rdata_reg, rdata_next;
    logic        addr_error_reg, addr_error_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [31:0] sent_id_reg, sent_id_next;
    logic [31:0] sent_data_reg, sent_data_next;
    logic [1:0]  irq_reg, irq_next;
    logic        dropped_reg, dropped_next;
    logic        size_ok;
    logic [31:0] wval;
    logic [31:0] rval;
    logic        rok;

    assign size_ok = (req.access_bytes != 3'd0) && (req.access_bytes <= 3'd4);
    assign wval    = cut_to_size(req.wdata, req.access_bytes);

    // read mux
    always_comb
    begin
        rval = '0;
        rok  = 1'b1;
        unique case (req.addr)
            ADDR_TX_ID:   rval = tx_id_reg;
            ADDR_TX_DATA: rval = tx_data_reg;
            ADDR_STATUS:  rval = {30'd0, 1'b1, !fifo_status.empty};
            ADDR_RX_ID:   rval = fifo_status.empty ? '0 : head_id;
            ADDR_RX_DATA: rval = fifo_status.empty ? '0 : head_data;
            default:      rok  = 1'b0;
        endcase
    end

    always_comb
    begin
        tx_id_next      = tx_id_reg;
        tx_data_next    = tx_data_reg;
        fifo_ctrl       = '0;
        rdata_next      = '0;
        addr_error_next = 1'b0;
        tx_valid_next   = 1'b0;
        sent_id_next    = '0;
        sent_data_next  = '0;
        irq_next        = IRQ_NONE;
        dropped_next    = 1'b0;
        if (req_valid)
        begin
            case (req.req_type)
                REQ_READ:
                begin
                    if (size_ok && rok)
                    begin
                        rdata_next = cut_to_size(rval, req.access_bytes);
                    end
                    else
                    begin
                        addr_error_next = 1'b1;
                    end
                end
                REQ_WRITE:
                begin
                    if (!size_ok)
                    begin
                        addr_error_next = 1'b1;
                    end
                    else
                    begin
                        unique case (req.addr)
                            ADDR_TX_ID:   tx_id_next = wval;
                            ADDR_TX_DATA: tx_data_next = wval;
                            ADDR_SEND:
                            begin
                                if (wval == 32'd1)
                                begin
                                    tx_valid_next  = 1'b1;
                                    sent_id_next   = tx_id_reg;
                                    sent_data_next = tx_data_reg;
                                end
                            end
                            ADDR_RX_POP:
                            begin
                                fifo_ctrl.pop = 1'b1;
                                irq_next = fifo_status.last ? IRQ_CLEAR : IRQ_SET;
                            end
                            default:      addr_error_next = 1'b1;
                        endcase
                    end
                end
                REQ_FRAME:
                begin
                    if (fifo_status.full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fifo_ctrl.push = 1'b1;
                        irq_next       = IRQ_SET;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_reg   <= '0;
            tx_data_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            tx_id_reg   <= tx_id_next;
            tx_data_reg <= tx_data_next;
            done_reg    <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg      <= rdata_next;
        addr_error_reg <= addr_error_next;
        tx_valid_reg   <= tx_valid_next;
        sent_id_reg    <= sent_id_next;
        sent_data_reg  <= sent_data_next;
        irq_reg        <= irq_next;
        dropped_reg    <= dropped_next;
    end

    assign done       = done_reg;
    assign rdata      = rdata_reg;
    assign addr_error = addr_error_reg;
    assign tx_valid   = tx_valid_reg;
    assign sent_id    = sent_id_reg;
    assign sent_data  = sent_data_reg;
    assign irq_event  = irq_reg;
    assign rx_dropped = dropped_reg;

endmodule
